### hdl/grpd_pkg.sv
// shared types, constants and hat lookup for the gamepad report decoder
`default_nettype none

package grpd_pkg;

    localparam int unsigned HELD_DEPTH    = 13;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned BTN_W         = 15;
    localparam int unsigned CFG_ADDR_W    = 2;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_ID  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CMD_ID   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BASIC_ID = 2'd2;

    localparam logic [BYTE_W-1:0] FULL_ID_RESET  = 8'd48;
    localparam logic [BYTE_W-1:0] CMD_ID_RESET   = 8'd33;
    localparam logic [BYTE_W-1:0] BASIC_ID_RESET = 8'd63;

    // hat codes of the basic report
    localparam logic [3:0] HAT_UP         = 4'd0;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
    localparam logic [3:0] HAT_RIGHT      = 4'd2;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd3;
    localparam logic [3:0] HAT_DOWN       = 4'd4;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
    localparam logic [3:0] HAT_LEFT       = 4'd6;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd7;

    typedef logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_t;

    typedef struct packed {
        logic shift;    // a byte is taken this cycle
        logic restart;  // that byte ends the report
    } cell_ctl_t;

    typedef struct packed {
        logic                    accepted;
        logic [BTN_W-1:0]        buttons;
        logic signed [BYTE_W-1:0] left_x;
        logic signed [BYTE_W-1:0] left_y;
        logic signed [BYTE_W-1:0] right_x;
        logic signed [BYTE_W-1:0] right_y;
    } result_t;

    // returns {right, left, down, up}
    function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
        logic [3:0] d;
        case (hat)
            HAT_UP:         d = 4'b0001;
            HAT_UP_RIGHT:   d = 4'b1001;
            HAT_RIGHT:      d = 4'b1000;
            HAT_DOWN_RIGHT: d = 4'b1010;
            HAT_DOWN:       d = 4'b0010;
            HAT_DOWN_LEFT:  d = 4'b0110;
            HAT_LEFT:       d = 4'b0100;
            HAT_UP_LEFT:    d = 4'b0101;
            default:        d = 4'b0000;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hdl/grpd_cell.sv
// one byte cell of the capture chain: holds a byte and passes the write token on
`default_nettype none

module grpd_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire grpd_pkg::cell_ctl_t         ctl_i,
    input  wire logic                        first_i,
    input  wire logic                        token_i,
    input  wire logic [grpd_pkg::BYTE_W-1:0] byte_i,
    output logic                             token_o,
    output logic [grpd_pkg::BYTE_W-1:0]      data_o
);

    logic                        token_reg;
    logic                        token_next;
    logic [grpd_pkg::BYTE_W-1:0] byte_reg;
    logic                        write;

    assign write = ctl_i.shift & token_reg;

    always_comb begin
        if (ctl_i.restart) begin
            token_next = first_i;
        end else if (ctl_i.shift) begin
            token_next = token_i;
        end else begin
            token_next = token_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_reg <= first_i;
        end else begin
            token_reg <= token_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (write) begin
            byte_reg <= byte_i;
        end
    end

    assign token_o = token_reg;
    // the byte written this cycle is already visible to the decoder
    assign data_o  = write ? byte_i : byte_reg;

endmodule

`default_nettype wire

### hdl/grpd_decode.sv
// report classification and field unpacking at end of report
`default_nettype none

module grpd_decode (
    input  wire grpd_pkg::held_t             held_i,
    input  wire logic                        len12_i,
    input  wire logic                        len13_i,
    input  wire logic                        skip_i,
    input  wire logic [grpd_pkg::BYTE_W-1:0] full_id_i,
    input  wire logic [grpd_pkg::BYTE_W-1:0] cmd_id_i,
    input  wire logic [grpd_pkg::BYTE_W-1:0] basic_id_i,
    output grpd_pkg::result_t                result_o,
    output logic                             skip_clear_o
);

    logic [grpd_pkg::BYTE_W-1:0] id;
    logic                        is_full;
    logic                        is_basic;
    logic [grpd_pkg::BTN_W-1:0]  btn_full;
    logic [grpd_pkg::BTN_W-1:0]  btn_basic;
    logic [3:0]                  hat;
    logic [grpd_pkg::BYTE_W-1:0] fl_x;
    logic [grpd_pkg::BYTE_W-1:0] fl_y;
    logic [grpd_pkg::BYTE_W-1:0] fr_x;
    logic [grpd_pkg::BYTE_W-1:0] fr_y;

    assign id       = held_i[0];
    assign is_full  = ((id == full_id_i) || (id == cmd_id_i)) && len13_i;
    assign is_basic = !is_full && (id == basic_id_i) && len12_i;
    assign skip_clear_o = is_basic & skip_i;

    assign btn_full = {held_i[5][5], held_i[5][4], held_i[5][7], held_i[5][6],
                       held_i[4][3], held_i[4][7], held_i[4][6],
                       held_i[3][0], held_i[5][0], held_i[3][1], held_i[5][1],
                       held_i[3][7], held_i[3][6], held_i[3][5], held_i[3][4]};

    assign hat = grpd_pkg::hat_dirs(held_i[3][3:0]);

    assign btn_basic = {hat, held_i[2][3], held_i[2][7], held_i[2][6],
                        held_i[1][0], held_i[1][1], held_i[1][2], held_i[1][3],
                        held_i[1][5], held_i[1][4], held_i[1][7], held_i[1][6]};

    // packed 12-bit axes: top eight bits minus center; y is negated with +128 clamped
    assign fl_x = {held_i[7][3:0], held_i[6][7:4]} ^ 8'h80;
    assign fr_x = {held_i[10][3:0], held_i[9][7:4]} ^ 8'h80;
    assign fl_y = (held_i[8]  == 8'd0) ? 8'h7F : (8'h80 - held_i[8]);
    assign fr_y = (held_i[11] == 8'd0) ? 8'h7F : (8'h80 - held_i[11]);

    always_comb begin
        result_o = '0;
        if (is_full) begin
            result_o.accepted = 1'b1;
            result_o.buttons  = btn_full;
            result_o.left_x   = fl_x;
            result_o.left_y   = fl_y;
            result_o.right_x  = fr_x;
            result_o.right_y  = fr_y;
        end else if (is_basic && !skip_i) begin
            result_o.accepted = 1'b1;
            result_o.buttons  = btn_basic;
            result_o.left_x   = held_i[4]  ^ 8'h80;
            result_o.left_y   = held_i[6]  ^ 8'h80;
            result_o.right_x  = held_i[8]  ^ 8'h80;
            result_o.right_y  = held_i[10] ^ 8'h80;
        end
    end

endmodule

`default_nettype wire

### hdl/gamepad_report_decoder.sv
// Gamepad report decoder: captures report bytes and emits one decoded word per report.
// Takes one byte per cycle; the result word appears in the cycle after the report's last byte is taken.
// Throughput is one byte per cycle, set by the capture cell chain; only a report's last byte
// waits, and only while the previous result word has not been taken.
// Reset (aresetn low, synchronous) puts the write token in cell 0, empties the output,
// arms the first-basic-report drop and restores the default report ids.
`default_nettype none

module gamepad_report_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // report_byte
    input  wire logic        s_tlast,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // buttons, left_x, left_y, right_x, right_y, pad
    output logic             m_tuser    // accepted
);

    localparam int unsigned N = grpd_pkg::HELD_DEPTH;

    logic [7:0]              full_id_reg;
    logic [7:0]              cmd_id_reg;
    logic [7:0]              basic_id_reg;
    logic                    skip_reg;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;
    grpd_pkg::result_t       result_reg;
    grpd_pkg::result_t       result_dec;
    grpd_pkg::cell_ctl_t     ctl;
    grpd_pkg::held_t         held;
    logic [N-1:0]            tokens;
    logic                    s_accept;
    logic                    load;
    logic                    skip_clear;
    logic                    len12;
    logic                    len13;

    // only the last byte needs the output register free
    assign s_tready = !m_valid_reg || m_tready || !s_tlast;
    assign s_accept = s_tvalid && s_tready;
    assign load     = s_accept && s_tlast;
    assign ctl.shift   = s_accept;
    assign ctl.restart = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_id_reg  <= grpd_pkg::FULL_ID_RESET;
            cmd_id_reg   <= grpd_pkg::CMD_ID_RESET;
            basic_id_reg <= grpd_pkg::BASIC_ID_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                grpd_pkg::REG_FULL_ID:  full_id_reg  <= cfg_wdata;
                grpd_pkg::REG_CMD_ID:   cmd_id_reg   <= cfg_wdata;
                grpd_pkg::REG_BASIC_ID: basic_id_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_cell
            grpd_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl_i   (ctl),
                .first_i ((i == 0) ? 1'b1 : 1'b0),
                .token_i ((i == 0) ? 1'b0 : tokens[(i == 0) ? 0 : i-1]),
                .byte_i  (s_tdata),
                .token_o (tokens[i]),
                .data_o  (held[i])
            );
        end
    endgenerate

    // token past the last cell: report already fills the chain
    always_comb begin
        if (ctl.restart) begin
            ovf_next = 1'b0;
        end else if (ctl.shift) begin
            ovf_next = ovf_reg | tokens[N-1];
        end else begin
            ovf_next = ovf_reg;
        end
    end

    assign len13 = tokens[N-1] | ovf_reg;
    assign len12 = tokens[N-2] | len13;

    grpd_decode u_decode (
        .held_i       (held),
        .len12_i      (len12),
        .len13_i      (len13),
        .skip_i       (skip_reg),
        .full_id_i    (full_id_reg),
        .cmd_id_i     (cmd_id_reg),
        .basic_id_i   (basic_id_reg),
        .result_o     (result_dec),
        .skip_clear_o (skip_clear)
    );

    assign m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_reg     <= 1'b0;
            skip_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (load && skip_clear) begin
                skip_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_dec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.accepted;
    assign m_tdata  = {1'b0, result_reg.right_y, result_reg.right_x,
                       result_reg.left_y, result_reg.left_x, result_reg.buttons};

    a_token_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({ovf_reg, tokens}))
        else $error("write token lost or duplicated");

    a_restart_token: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (tokens[0] && !ovf_reg))
        else $error("token not back at first cell after report end");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !result_reg.accepted) |-> (m_tdata == '0))
        else $error("rejected report carries nonzero fields");

    a_skip_no_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        !$rose(skip_reg))
        else $error("first-basic drop flag re-armed");

    a_skip_only_basic: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(skip_reg) |-> ($past(load) && m_valid_reg && !result_reg.accepted))
        else $error("drop flag cleared without a dropped report");

endmodule

`default_nettype wire

### sim/tb.sv
// self-checking testbench for the gamepad report decoder: byte stream in, decoded words out
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FULL_MIN_LEN  = 13;
    localparam int unsigned BASIC_MIN_LEN = 12;
    localparam int unsigned COUNT_CAP     = 15;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned CYCLE_LIMIT   = 300000;

    // index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    // button bit positions of the result word
    localparam int BTN_A     = 0;
    localparam int BTN_B     = 1;
    localparam int BTN_X     = 2;
    localparam int BTN_Y     = 3;
    localparam int BTN_L     = 4;
    localparam int BTN_R     = 5;
    localparam int BTN_ZL    = 6;
    localparam int BTN_ZR    = 7;
    localparam int BTN_PLUS  = 8;
    localparam int BTN_MINUS = 9;
    localparam int BTN_HOME  = 10;
    localparam int BTN_UP    = 11;
    localparam int BTN_DOWN  = 12;
    localparam int BTN_LEFT  = 13;
    localparam int BTN_RIGHT = 14;

    typedef struct {
        logic [7:0]  value;
        logic        ends;
        int unsigned pause;
    } report_word_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // report_byte
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;           // buttons, left_x, left_y, right_x, right_y, pad
    logic        m_tuser;           // accepted

    gamepad_report_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // decoder shadow state
    logic [7:0]  full_id         = grpd_pkg::FULL_ID_RESET;
    logic [7:0]  cmd_id          = grpd_pkg::CMD_ID_RESET;
    logic [7:0]  basic_id        = grpd_pkg::BASIC_ID_RESET;
    logic [7:0]  held [grpd_pkg::HELD_DEPTH];
    int unsigned bytes_seen      = 0;
    logic        drop_next_basic = 1'b1;

    report_word_t      pending_words[$];
    grpd_pkg::result_t expected_results[$];
    logic [7:0]        body[$];

    int unsigned errors       = 0;
    int unsigned cycles       = 0;
    int unsigned idle_waited  = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    logic        sender_idle  = 1'b0;
    logic        recv_idle    = 1'b0;
    logic        hold_toggle  = 1'b0;
    logic        hold_seen    = 1'b0;
    int unsigned bytes_queued = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [7:0] clamp8(input int v);
        if (v > 127) return 8'sd127;
        if (v < -128) return -8'sd128;
        return v[7:0];
    endfunction

    // 12-bit packed sticks keep only their upper 8 bits after the shift by 4
    function automatic grpd_pkg::result_t decode_full();
        grpd_pkg::result_t r;
        logic [7:0] rb, sb, lb;
        rb = held[3];
        sb = held[4];
        lb = held[5];
        r = '0;
        r.accepted          = 1'b1;
        r.buttons[BTN_A]     = rb[4];
        r.buttons[BTN_B]     = rb[5];
        r.buttons[BTN_X]     = rb[6];
        r.buttons[BTN_Y]     = rb[7];
        r.buttons[BTN_R]     = rb[1];
        r.buttons[BTN_ZR]    = rb[0];
        r.buttons[BTN_PLUS]  = sb[6];
        r.buttons[BTN_MINUS] = sb[7];
        r.buttons[BTN_HOME]  = sb[3];
        r.buttons[BTN_L]     = lb[1];
        r.buttons[BTN_ZL]    = lb[0];
        r.buttons[BTN_LEFT]  = lb[4];
        r.buttons[BTN_RIGHT] = lb[5];
        r.buttons[BTN_UP]    = lb[6];
        r.buttons[BTN_DOWN]  = lb[7];
        r.left_x  = clamp8(int'({held[7][3:0], held[6][7:4]}) - 128);
        r.left_y  = clamp8(128 - int'(held[8]));
        r.right_x = clamp8(int'({held[10][3:0], held[9][7:4]}) - 128);
        r.right_y = clamp8(128 - int'(held[11]));
        return r;
    endfunction

    // big-endian sticks: only the high byte survives the shift by 8
    function automatic grpd_pkg::result_t decode_basic();
        grpd_pkg::result_t r;
        logic [7:0] pb, sb;
        pb = held[1];
        sb = held[2];
        r = '0;
        r.accepted           = 1'b1;
        r.buttons[BTN_A]     = pb[6];
        r.buttons[BTN_B]     = pb[7];
        r.buttons[BTN_X]     = pb[4];
        r.buttons[BTN_Y]     = pb[5];
        r.buttons[BTN_L]     = pb[3];
        r.buttons[BTN_R]     = pb[2];
        r.buttons[BTN_ZL]    = pb[1];
        r.buttons[BTN_ZR]    = pb[0];
        r.buttons[BTN_PLUS]  = sb[6];
        r.buttons[BTN_MINUS] = sb[7];
        r.buttons[BTN_HOME]  = sb[3];
        case (held[3][3:0])
            grpd_pkg::HAT_UP:         r.buttons[BTN_UP] = 1'b1;
            grpd_pkg::HAT_UP_RIGHT: begin
                r.buttons[BTN_UP]    = 1'b1;
                r.buttons[BTN_RIGHT] = 1'b1;
            end
            grpd_pkg::HAT_RIGHT:      r.buttons[BTN_RIGHT] = 1'b1;
            grpd_pkg::HAT_DOWN_RIGHT: begin
                r.buttons[BTN_DOWN]  = 1'b1;
                r.buttons[BTN_RIGHT] = 1'b1;
            end
            grpd_pkg::HAT_DOWN:       r.buttons[BTN_DOWN] = 1'b1;
            grpd_pkg::HAT_DOWN_LEFT: begin
                r.buttons[BTN_DOWN] = 1'b1;
                r.buttons[BTN_LEFT] = 1'b1;
            end
            grpd_pkg::HAT_LEFT:       r.buttons[BTN_LEFT] = 1'b1;
            grpd_pkg::HAT_UP_LEFT: begin
                r.buttons[BTN_UP]   = 1'b1;
                r.buttons[BTN_LEFT] = 1'b1;
            end
            default: ;
        endcase
        r.left_x  = clamp8(int'(held[4]) - 128);
        r.left_y  = clamp8(int'(held[6]) - 128);
        r.right_x = clamp8(int'(held[8]) - 128);
        r.right_y = clamp8(int'(held[10]) - 128);
        return r;
    endfunction

    task automatic track_byte(input logic [7:0] value, input logic ends);
        grpd_pkg::result_t r;
        int unsigned       len;
        logic [7:0]        id;
        if (bytes_seen < grpd_pkg::HELD_DEPTH) held[bytes_seen] = value;
        if (bytes_seen < COUNT_CAP) bytes_seen++;
        if (ends) begin
            len        = bytes_seen;
            bytes_seen = 0;
            id         = held[0];
            r          = '0;
            if ((id == full_id || id == cmd_id) && len >= FULL_MIN_LEN) begin
                r = decode_full();
            end else if (id == basic_id && len >= BASIC_MIN_LEN) begin
                if (drop_next_basic) drop_next_basic = 1'b0;
                else r = decode_basic();
            end
            expected_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver: one word per handshake, optional pause before each word
    always @(posedge aclk) begin : drive_words
        report_word_t w;
        if (!aresetn) begin
            s_tvalid    <= 1'b0;
            idle_waited = 0;
        end else begin
            if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && idle_waited >= pending_words[0].pause) begin
                    w = pending_words.pop_front();
                    s_tdata     <= w.value;
                    s_tlast     <= w.ends;
                    s_tvalid    <= 1'b1;
                    idle_waited = 0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (pending_words.size() != 0) idle_waited++;
                end
            end
        end
    end

    // monitor: checks each result word and throttles m_tready
    always @(posedge aclk) begin : watch_results
        grpd_pkg::result_t want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result expected none actual accepted %0b data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("accepted", want.accepted, m_tuser);
                    check_field("buttons", want.buttons, m_tdata[14:0]);
                    check_field("left_x", want.left_x, $signed(m_tdata[22:15]));
                    check_field("left_y", want.left_y, $signed(m_tdata[30:23]));
                    check_field("right_x", want.right_x, $signed(m_tdata[38:31]));
                    check_field("right_y", want.right_y, $signed(m_tdata[46:39]));
                end
                stall_left = recv_idle ? $urandom_range(0, 19) : 0;
            end
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            grpd_pkg::REG_FULL_ID:  full_id  = val;
            grpd_pkg::REG_CMD_ID:   cmd_id   = val;
            grpd_pkg::REG_BASIC_ID: basic_id = val;
            default: ;
        endcase
    endtask

    // fill < 0 gives random bytes after the id
    task automatic build(input logic [7:0] id, input int len, input int fill);
        body.delete();
        body.push_back(id);
        for (int i = 1; i < len; i++)
            body.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    endtask

    task automatic send();
        report_word_t w;
        foreach (body[i]) begin
            w.value = body[i];
            w.ends  = (i == body.size() - 1);
            w.pause = sender_idle ? $urandom_range(0, 19) : 0;
            pending_words.push_back(w);
            bytes_queued++;
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_reports(input int unsigned target, input bit allow_idle);
        int unsigned pick;
        logic [7:0]  id;
        int          len;
        bytes_queued = 0;
        @(negedge aclk);
        while (bytes_queued < target) begin
            sender_idle = allow_idle && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: begin
                    id  = $urandom_range(0, 1) ? full_id : cmd_id;
                    len = $urandom_range(FULL_MIN_LEN, COUNT_CAP);
                end
                4, 5, 6: begin
                    id  = basic_id;
                    len = $urandom_range(BASIC_MIN_LEN, COUNT_CAP);
                end
                7: begin
                    case ($urandom_range(0, 2))
                        0: id = full_id;
                        1: id = cmd_id;
                        default: id = basic_id;
                    endcase
                    len = $urandom_range(1, FULL_MIN_LEN - 1);
                end
                8: begin
                    id  = 8'($urandom);
                    len = $urandom_range(1, 20);
                end
                default: begin
                    id  = $urandom_range(0, 1) ? full_id : basic_id;
                    len = $urandom_range(16, 24);
                end
            endcase
            build(id, len, -1);
            send();
        end
    endtask

    initial begin
        for (int i = 0; i < grpd_pkg::HELD_DEPTH; i++) held[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed reports at the reset ids
        @(negedge aclk);
        sender_idle = 1'b0;
        build(grpd_pkg::BASIC_ID_RESET, 12, -1);    // first basic report is dropped
        send();
        build(grpd_pkg::BASIC_ID_RESET, 12, 8'h00);
        send();
        build(grpd_pkg::BASIC_ID_RESET, 12, 8'hff);
        send();
        for (int h = 0; h < 9; h++) begin
            build(grpd_pkg::BASIC_ID_RESET, 12, -1);
            body[3] = {4'($urandom), 4'(h)};
            send();
        end
        build(grpd_pkg::FULL_ID_RESET, 13, 8'h00);
        send();
        build(grpd_pkg::FULL_ID_RESET, 13, 8'hff);
        send();
        build(grpd_pkg::CMD_ID_RESET, 15, -1);      // sticks at center
        body[6] = 8'h00;
        body[7] = 8'h08;
        body[8] = 8'h80;
        body[9] = 8'h00;
        body[10] = 8'h08;
        body[11] = 8'h80;
        send();
        build(grpd_pkg::FULL_ID_RESET, 12, -1);     // too short for full
        send();
        build(grpd_pkg::BASIC_ID_RESET, 11, -1);    // too short for basic
        send();
        build(8'd0, 13, -1);                        // unknown id
        send();
        build(grpd_pkg::FULL_ID_RESET, 1, 0);
        send();
        build(grpd_pkg::CMD_ID_RESET, 20, -1);      // count saturates
        send();
        drain();

        // full and basic share one id, extremes of the register range
        recv_idle <= 1'b1;
        set_reg(grpd_pkg::REG_FULL_ID, 8'd0);
        set_reg(grpd_pkg::REG_CMD_ID, 8'd255);
        set_reg(grpd_pkg::REG_BASIC_ID, 8'd0);
        set_reg(REG_SPARE, 8'($urandom));
        @(negedge aclk);
        build(8'd0, 13, -1);
        send();
        build(8'd0, 12, -1);
        send();
        random_reports(150, 1'b1);
        drain();

        set_reg(grpd_pkg::REG_FULL_ID, 8'd255);
        set_reg(grpd_pkg::REG_CMD_ID, 8'd0);
        set_reg(grpd_pkg::REG_BASIC_ID, 8'd255);
        recv_idle <= 1'b0;
        random_reports(150, 1'b1);
        drain();

        // receiver holds off long while the sender streams without gaps
        hold_toggle <= ~hold_toggle;
        random_reports(330, 1'b0);
        drain();

        set_reg(grpd_pkg::REG_FULL_ID, 8'($urandom));
        set_reg(grpd_pkg::REG_CMD_ID, 8'($urandom));
        set_reg(grpd_pkg::REG_BASIC_ID, $urandom_range(0, 1) ? full_id : 8'($urandom));
        recv_idle <= 1'b1;
        random_reports(150, 1'b1);
        drain();

        set_reg(grpd_pkg::REG_FULL_ID, grpd_pkg::FULL_ID_RESET);
        set_reg(grpd_pkg::REG_CMD_ID, grpd_pkg::CMD_ID_RESET);
        set_reg(grpd_pkg::REG_BASIC_ID, grpd_pkg::BASIC_ID_RESET);
        set_reg(REG_SPARE, 8'($urandom));
        recv_idle <= 1'b0;
        random_reports(150, 1'b1);
        drain();

        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
